// ===== rtl/core/sdert_pkg.sv =====
// shared types and constants of the sync deframer with echo and round-trip table
`timescale 1ns / 1ps
package sdert_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam logic [31:0] SYNC_RESET        = 32'hCAFE_BAB0;
  localparam int unsigned HDR_LEN           = 32;
  localparam logic [63:0] DEFAULT_NAN       = 64'hFFF8_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_HEAD,
    ST_PAY,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ECHO_RD,
    ST_ECHO_WR,
    ST_SUB
  } state_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_ALIGN,
    FS_NORM,
    FS_ROUND
  } fsub_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } fsub_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fsub_rsp_t;

endpackage

// ===== rtl/core/sdert_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sdert_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sdert_fsub.sv =====
// multi-cycle ieee double subtractor, round to nearest even
`timescale 1ns / 1ps
module sdert_fsub (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdert_pkg::fsub_req_t req_i,
  output sdert_pkg::fsub_rsp_t rsp_o
);

  sdert_pkg::fsub_state_e state_q, state_d;
  logic        sign_q, sign_d;
  logic        sub_q, sub_d;
  logic [11:0] e_q, e_d;
  logic [11:0] dist_q, dist_d;
  logic [55:0] ml_q, ml_d;
  logic [55:0] ms_q, ms_d;
  logic [56:0] acc_q, acc_d;
  logic [63:0] res_q, res_d;
  logic        done_q, done_d;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_ge, sbn;
  logic [55:0] ma, mb, sh, mask;
  logic [11:0] eax, ebx;
  logic [56:0] sum;
  logic [53:0] rnd;
  logic [11:0] e2;
  logic        inc;

  always_comb begin
    ea    = req_i.a[62:52];
    fa    = req_i.a[51:0];
    eb    = req_i.b[62:52];
    fb    = req_i.b[51:0];
    a_nan = (ea == 11'h7FF) && (fa != 52'd0);
    b_nan = (eb == 11'h7FF) && (fb != 52'd0);
    a_inf = (ea == 11'h7FF) && (fa == 52'd0);
    b_inf = (eb == 11'h7FF) && (fb == 52'd0);
    a_ge  = req_i.a[62:0] >= req_i.b[62:0];
    sbn   = ~req_i.b[63];
    eax   = (ea == 11'd0) ? 12'd1 : {1'b0, ea};
    ebx   = (eb == 11'd0) ? 12'd1 : {1'b0, eb};
    ma    = {(ea != 11'd0), fa, 3'b000};
    mb    = {(eb != 11'd0), fb, 3'b000};

    mask = ~({56{1'b1}} << dist_q[5:0]);
    if (dist_q >= 12'd56) begin
      sh = {55'd0, |ms_q};
    end else begin
      sh = (ms_q >> dist_q[5:0]) | {55'd0, |(ms_q & mask)};
    end
    sum = sub_q ? ({1'b0, ml_q} - {1'b0, sh}) : ({1'b0, ml_q} + {1'b0, sh});

    inc = acc_q[2] & (acc_q[1] | acc_q[0] | acc_q[3]);
    rnd = {1'b0, acc_q[55:3]} + {53'd0, inc};
    e2  = e_q + {11'd0, rnd[53]};
  end

  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    sub_d   = sub_q;
    e_d     = e_q;
    dist_d  = dist_q;
    ml_d    = ml_q;
    ms_d    = ms_q;
    acc_d   = acc_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      sdert_pkg::FS_IDLE: begin
        if (req_i.start) begin
          priority if (a_nan) begin
            res_d  = req_i.a | (64'd1 << 51);
            done_d = 1'b1;
          end else if (b_nan) begin
            res_d  = req_i.b | (64'd1 << 51);
            done_d = 1'b1;
          end else if (a_inf && b_inf) begin
            res_d  = (req_i.a[63] == req_i.b[63]) ? sdert_pkg::DEFAULT_NAN : req_i.a;
            done_d = 1'b1;
          end else if (a_inf) begin
            res_d  = req_i.a;
            done_d = 1'b1;
          end else if (b_inf) begin
            res_d  = {sbn, req_i.b[62:0]};
            done_d = 1'b1;
          end else begin
            sub_d   = req_i.a[63] != sbn;
            state_d = sdert_pkg::FS_ALIGN;
            if (a_ge) begin
              sign_d = req_i.a[63];
              e_d    = eax;
              ml_d   = ma;
              ms_d   = mb;
              dist_d = eax - ebx;
            end else begin
              sign_d = sbn;
              e_d    = ebx;
              ml_d   = mb;
              ms_d   = ma;
              dist_d = ebx - eax;
            end
          end
        end
      end
      sdert_pkg::FS_ALIGN: begin
        if (sum == 57'd0) begin
          res_d   = {(sub_q ? 1'b0 : sign_q), 63'd0};
          done_d  = 1'b1;
          state_d = sdert_pkg::FS_IDLE;
        end else begin
          acc_d   = sum;
          state_d = sdert_pkg::FS_NORM;
        end
      end
      sdert_pkg::FS_NORM: begin
        priority if (acc_q[56]) begin
          acc_d = {1'b0, acc_q[56:2], acc_q[1] | acc_q[0]};
          e_d   = e_q + 12'd1;
        end else if (!acc_q[55] && (e_q > 12'd1)) begin
          acc_d = {acc_q[55:0], 1'b0};
          e_d   = e_q - 12'd1;
        end else begin
          state_d = sdert_pkg::FS_ROUND;
        end
      end
      sdert_pkg::FS_ROUND: begin
        if (e2 >= 12'd2047) begin
          res_d = {sign_q, 11'h7FF, 52'd0};
        end else if (rnd[53]) begin
          res_d = {sign_q, e2[10:0], 52'd0};
        end else begin
          res_d = {sign_q, (rnd[52] ? e2[10:0] : 11'd0), rnd[51:0]};
        end
        done_d  = 1'b1;
        state_d = sdert_pkg::FS_IDLE;
      end
      default: state_d = sdert_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdert_pkg::FS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    sub_q  <= sub_d;
    e_q    <= e_d;
    dist_q <= dist_d;
    ml_q   <= ml_d;
    ms_q   <= ms_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  a_norm_keeps_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdert_pkg::FS_ROUND) |-> !acc_q[56])
    else $error("carry left at rounding");
  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sdert_pkg::FS_IDLE) |=> !done_q || $past(state_q == sdert_pkg::FS_ALIGN
      || state_q == sdert_pkg::FS_ROUND))
    else $error("done from wrong step");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdert_pkg::FS_NORM) |=> !done_q)
    else $error("done while normalizing");

endmodule

// ===== rtl/core/sync_deframer_echo_rtt_table.sv =====
// top level: sync hunt, header capture, echo and round-trip table
// hunt and header bytes: one item per cycle while no output item is pending, no result until header byte 31
// payload bytes: an echoed byte waits in the output register and holds off input until taken
// header end: table scan (read then compare per entry, stopping at a hit), then echo read and write per header item
// round-trip record: table scan, then the multi-cycle double subtractor
// reset clears all table valid bits at once; no clearing pass
`timescale 1ns / 1ps
module sync_deframer_echo_rtt_table #(
  parameter int unsigned TABLE_ENTRIES = sdert_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  echo_byte_o,
  output logic        last_o,
  output logic [63:0] rtt_bits_o,
  output logic [32:0] packet_length_o,
  output logic [31:0] device_id_o,
  output logic [31:0] packet_index_o,
  output logic        network_is_wifi_o,
  output logic        insert_dropped_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  sdert_pkg::state_e state_q, state_d;
  logic [31:0] sync_q, sync_d;
  logic [31:0] win_q, win_d;
  logic [2:0]  fill_q, fill_d;
  logic [4:0]  hc_q, hc_d;
  logic [31:0] left_q, left_d;
  logic        echo_q, echo_d;
  logic        drop_q, drop_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0] sidx_q, sidx_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic        ffound_q, ffound_d;
  logic [4:0]  eidx_q, eidx_d;
  logic        ov_q, ov_d;

  logic [31:0] shdr_q, shdr_d;
  logic [31:0] dev_q, dev_d;
  logic [31:0] typ_q, typ_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] net_q, net_d;
  logic [63:0] stamp_q, stamp_d;
  logic [31:0] len_q, len_d;

  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [63:0] rtt_q, rtt_d;
  logic        odrop_q, odrop_d;

  logic        in_acc;
  logic [31:0] win_n;
  logic [2:0]  fill_n;
  logic [31:0] len_full, typ_full;
  logic [7:0]  hram_rd;
  logic        tram_we;
  logic [IW-1:0] tram_wa;
  logic [95:0] tram_wd, tram_rd;
  logic        hit;
  logic [31:0] left_m1;
  sdert_pkg::fsub_req_t fs_req;
  sdert_pkg::fsub_rsp_t fs_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ov_q || !((state_q == sdert_pkg::ST_HUNT) ||
                                 (state_q == sdert_pkg::ST_HEAD) ||
                                 (state_q == sdert_pkg::ST_PAY));
  assign in_acc      = in_valid_i && !in_stall_o;

  assign win_n    = {rx_byte_i, win_q[31:8]};
  assign fill_n   = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
  assign len_full = {rx_byte_i, len_q[23:0]};
  assign typ_full = typ_q;
  assign hit      = valid_q[sidx_q] && (tram_rd[95:64] == idx_q);
  assign left_m1  = left_q - 32'd1;

  sdert_ram #(.WIDTH(8), .DEPTH(sdert_pkg::HDR_LEN)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && (state_q == sdert_pkg::ST_HEAD)),
    .waddr_i(hc_q),
    .wdata_i(rx_byte_i),
    .raddr_i(eidx_q),
    .rdata_o(hram_rd)
  );

  sdert_ram #(.WIDTH(96), .DEPTH(TABLE_ENTRIES)) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (tram_we),
    .waddr_i(tram_wa),
    .wdata_i(tram_wd),
    .raddr_i(sidx_q),
    .rdata_o(tram_rd)
  );

  sdert_fsub u_fsub (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fs_req),
    .rsp_o (fs_rsp)
  );

  // field capture while the header streams in
  always_comb begin
    dev_d   = dev_q;
    typ_d   = typ_q;
    idx_d   = idx_q;
    net_d   = net_q;
    stamp_d = stamp_q;
    len_d   = len_q;
    if (in_acc && (state_q == sdert_pkg::ST_HEAD)) begin
      unique case (hc_q[4:2])
        3'd1: dev_d[8*hc_q[1:0] +: 8] = rx_byte_i;
        3'd2: typ_d[8*hc_q[1:0] +: 8] = rx_byte_i;
        3'd3: idx_d[8*hc_q[1:0] +: 8] = rx_byte_i;
        3'd4: net_d[8*hc_q[1:0] +: 8] = rx_byte_i;
        3'd5: stamp_d[8*{1'b0, hc_q[1:0]} +: 8] = rx_byte_i;
        3'd6: stamp_d[8*{1'b1, hc_q[1:0]} +: 8] = rx_byte_i;
        3'd7: len_d[8*hc_q[1:0] +: 8] = rx_byte_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdert_pkg::ST_HUNT: begin
        if (in_acc && (fill_n == 3'd4) && (win_n == sync_q)) begin
          state_d = sdert_pkg::ST_HEAD;
        end
      end
      sdert_pkg::ST_HEAD: begin
        if (in_acc && (hc_q == 5'd31)) begin
          priority if (typ_full == 32'd0) state_d = sdert_pkg::ST_SCAN_RD;
          else if (len_full == 32'd0)     state_d = sdert_pkg::ST_SCAN_RD;
          else                            state_d = sdert_pkg::ST_PAY;
        end
      end
      sdert_pkg::ST_PAY: begin
        if (in_acc && (left_m1 == 32'd0)) begin
          state_d = echo_q ? sdert_pkg::ST_HUNT : sdert_pkg::ST_SCAN_RD;
        end
      end
      sdert_pkg::ST_SCAN_RD: state_d = sdert_pkg::ST_SCAN_CMP;
      sdert_pkg::ST_SCAN_CMP: begin
        priority if (hit) begin
          state_d = echo_q ? sdert_pkg::ST_ECHO_RD : sdert_pkg::ST_SUB;
        end else if (sidx_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = echo_q ? sdert_pkg::ST_ECHO_RD : sdert_pkg::ST_HUNT;
        end else begin
          state_d = sdert_pkg::ST_SCAN_RD;
        end
      end
      sdert_pkg::ST_ECHO_RD: state_d = sdert_pkg::ST_ECHO_WR;
      sdert_pkg::ST_ECHO_WR: begin
        if (!ov_q) begin
          priority if (eidx_q != 5'd31) state_d = sdert_pkg::ST_ECHO_RD;
          else if (len_q == 32'd0)      state_d = sdert_pkg::ST_HUNT;
          else                          state_d = sdert_pkg::ST_PAY;
        end
      end
      sdert_pkg::ST_SUB: begin
        if (fs_rsp.done) state_d = sdert_pkg::ST_HUNT;
      end
      default: state_d = sdert_pkg::ST_HUNT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sync_d   = cfg_valid_i ? cfg_data_i : sync_q;
    win_d    = win_q;
    fill_d   = fill_q;
    hc_d     = hc_q;
    left_d   = left_q;
    echo_d   = echo_q;
    drop_d   = drop_q;
    valid_d  = valid_q;
    sidx_d   = sidx_q;
    fidx_d   = fidx_q;
    ffound_d = ffound_q;
    eidx_d   = eidx_q;
    shdr_d   = shdr_q;
    ov_d     = ov_q && out_stall_i;
    kind_d   = kind_q;
    byte_d   = byte_q;
    last_d   = last_q;
    rtt_d    = rtt_q;
    odrop_d  = odrop_q;
    tram_we  = 1'b0;
    tram_wa  = sidx_q;
    tram_wd  = {idx_q, stamp_q};
    fs_req.start = 1'b0;
    fs_req.a     = stamp_q;
    fs_req.b     = tram_rd[63:0];
    unique case (state_q)
      sdert_pkg::ST_HUNT: begin
        if (in_acc) begin
          win_d  = win_n;
          fill_d = fill_n;
          if ((fill_n == 3'd4) && (win_n == sync_q)) begin
            shdr_d = win_n;
            hc_d   = 5'd4;
          end
        end
      end
      sdert_pkg::ST_HEAD: begin
        if (in_acc) begin
          hc_d = hc_q + 5'd1;
          if (hc_q == 5'd31) begin
            left_d   = len_full;
            echo_d   = typ_full == 32'd0;
            sidx_d   = '0;
            ffound_d = 1'b0;
            eidx_d   = 5'd0;
          end
        end
      end
      sdert_pkg::ST_PAY: begin
        if (in_acc) begin
          left_d = left_m1;
          if (echo_q) begin
            ov_d    = 1'b1;
            kind_d  = 1'b0;
            byte_d  = rx_byte_i;
            last_d  = left_m1 == 32'd0;
            rtt_d   = 64'd0;
            odrop_d = drop_q;
          end
          if (left_m1 == 32'd0) begin
            sidx_d   = '0;
            ffound_d = 1'b0;
          end
        end
      end
      sdert_pkg::ST_SCAN_RD: ;
      sdert_pkg::ST_SCAN_CMP: begin
        if (!valid_q[sidx_q] && !ffound_q) begin
          ffound_d = 1'b1;
          fidx_d   = sidx_q;
        end
        priority if (hit) begin
          if (echo_q) begin
            tram_we = 1'b1;
            drop_d  = 1'b0;
          end else begin
            valid_d[sidx_q] = 1'b0;
            fs_req.start    = 1'b1;
          end
        end else if (sidx_q == IW'(TABLE_ENTRIES - 1)) begin
          if (echo_q) begin
            if (ffound_d) begin
              tram_we          = 1'b1;
              tram_wa          = fidx_d;
              valid_d[fidx_d]  = 1'b1;
              drop_d           = 1'b0;
            end else begin
              drop_d = 1'b1;
            end
          end
        end else begin
          sidx_d = sidx_q + IW'(1);
        end
      end
      sdert_pkg::ST_ECHO_RD: ;
      sdert_pkg::ST_ECHO_WR: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          kind_d  = 1'b0;
          byte_d  = (eidx_q < 5'd4) ? shdr_q[8*eidx_q[1:0] +: 8] : hram_rd;
          last_d  = (eidx_q == 5'd31) && (len_q == 32'd0);
          rtt_d   = 64'd0;
          odrop_d = drop_q;
          eidx_d  = eidx_q + 5'd1;
        end
      end
      sdert_pkg::ST_SUB: begin
        if (fs_rsp.done) begin
          ov_d    = 1'b1;
          kind_d  = 1'b1;
          byte_d  = 8'd0;
          last_d  = 1'b1;
          rtt_d   = fs_rsp.res;
          odrop_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (state_d == sdert_pkg::ST_HUNT && state_q != sdert_pkg::ST_HUNT) begin
      win_d  = 32'd0;
      fill_d = 3'd0;
      hc_d   = 5'd0;
      left_d = 32'd0;
      echo_d = 1'b0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdert_pkg::ST_HUNT;
      sync_q   <= sdert_pkg::SYNC_RESET;
      win_q    <= 32'd0;
      fill_q   <= 3'd0;
      hc_q     <= 5'd0;
      left_q   <= 32'd0;
      echo_q   <= 1'b0;
      drop_q   <= 1'b0;
      valid_q  <= '0;
      sidx_q   <= '0;
      fidx_q   <= '0;
      ffound_q <= 1'b0;
      eidx_q   <= 5'd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      sync_q   <= sync_d;
      win_q    <= win_d;
      fill_q   <= fill_d;
      hc_q     <= hc_d;
      left_q   <= left_d;
      echo_q   <= echo_d;
      drop_q   <= drop_d;
      valid_q  <= valid_d;
      sidx_q   <= sidx_d;
      fidx_q   <= fidx_d;
      ffound_q <= ffound_d;
      eidx_q   <= eidx_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shdr_q  <= shdr_d;
    dev_q   <= dev_d;
    typ_q   <= typ_d;
    idx_q   <= idx_d;
    net_q   <= net_d;
    stamp_q <= stamp_d;
    len_q   <= len_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    rtt_q   <= rtt_d;
    odrop_q <= odrop_d;
  end

  assign out_valid_o       = ov_q;
  assign kind_o            = kind_q;
  assign echo_byte_o       = byte_q;
  assign last_o            = last_q;
  assign rtt_bits_o        = rtt_q;
  assign packet_length_o   = {1'b0, len_q} + 33'(sdert_pkg::HDR_LEN);
  assign device_id_o       = dev_q;
  assign packet_index_o    = idx_q;
  assign network_is_wifi_o = net_q != 32'd0;
  assign insert_dropped_o  = odrop_q;

  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("item taken while result pending");
  a_sub_done_in_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_rsp.done |-> (state_q == sdert_pkg::ST_SUB))
    else $error("subtractor result outside lookup");
  a_echo_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdert_pkg::ST_ECHO_WR && !ov_q) |=> ov_q)
    else $error("header echo item lost");
  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdert_pkg::ST_HEAD) |-> (hc_q >= 5'd4))
    else $error("header count below sync length");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the sync deframer with echo and round-trip table
`timescale 1ns / 1ps
module testbench;

  // small table so that full-table drops show up within a short run
  localparam int TB_ENTRIES = 2;

  typedef struct packed {
    bit        kind;
    bit [7:0]  echo_byte;
    bit        last;
    bit [63:0] rtt_bits;
    bit [32:0] packet_length;
    bit [31:0] device_id;
    bit [31:0] packet_index;
    bit        wifi;
    bit        dropped;
  } frame_result_t;

  typedef enum int { HUNT, HEAD, PAY } deframe_phase_e;

  class echo_rtt_scoreboard;
    bit [31:0]      sync_word;
    bit [31:0]      window;
    int             fill;
    deframe_phase_e phase;
    bit [7:0]       hdr [32];
    int             hdr_count;
    bit [31:0]      pay_left;
    bit             echo_on;
    bit             drop_on;
    bit             slot_used [TB_ENTRIES];
    bit [31:0]      slot_key [TB_ENTRIES];
    bit [63:0]      slot_stamp [TB_ENTRIES];
    frame_result_t  pending [$];
    int             errors, echoes, records, drops;

    function void clear_hunt();
      phase = HUNT;
      window = '0;
      fill = 0;
      hdr_count = 0;
      pay_left = '0;
      echo_on = 0;
      drop_on = 0;
    endfunction

    function void init();
      sync_word = sdert_pkg::SYNC_RESET;
      clear_hunt();
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function bit [31:0] hdr32(int off);
      return {hdr[off + 3], hdr[off + 2], hdr[off + 1], hdr[off]};
    endfunction

    function void add(bit kind, bit [7:0] b, bit last, bit [63:0] rtt, bit dropped);
      frame_result_t r;
      r.kind = kind;
      r.echo_byte = b;
      r.last = last;
      r.rtt_bits = rtt;
      r.packet_length = 33'd32 + hdr32(28);
      r.device_id = hdr32(4);
      r.packet_index = hdr32(12);
      r.wifi = hdr32(16) != 0;
      r.dropped = dropped;
      pending.push_back(r);
      if (kind) records++;
      else echoes++;
      if (dropped) drops++;
    endfunction

    function bit is_nan(bit [63:0] v);
      return v[62:52] == 11'h7ff && v[51:0] != 0;
    endfunction

    function void lookup_rtt();
      bit [63:0] now_bits, diff_bits;
      now_bits = {hdr32(24), hdr32(20)};
      for (int i = 0; i < TB_ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == hdr32(12)) begin
          // nan operands propagate quieted, first operand first
          if (is_nan(now_bits)) begin
            diff_bits = now_bits | (64'd1 << 51);
          end else if (is_nan(slot_stamp[i])) begin
            diff_bits = slot_stamp[i] | (64'd1 << 51);
          end else begin
            diff_bits = $realtobits($bitstoreal(now_bits) - $bitstoreal(slot_stamp[i]));
            if (is_nan(diff_bits)) diff_bits = sdert_pkg::DEFAULT_NAN;
          end
          slot_used[i] = 0;
          add(1, 8'h00, 1, diff_bits, 0);
          return;
        end
      end
    endfunction

    function bit insert_stamp(bit [31:0] k, bit [63:0] s);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < TB_ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == k) begin
          slot_stamp[i] = s;
          return 1;
        end
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot < 0) return 0;
      slot_used[free_slot] = 1;
      slot_key[free_slot] = k;
      slot_stamp[free_slot] = s;
      return 1;
    endfunction

    function void note_byte(bit [7:0] b);
      if (phase == HEAD) begin
        hdr[hdr_count] = b;
        hdr_count++;
        if (hdr_count < 32) return;
        pay_left = hdr32(28);
        if (hdr32(8) == 0) begin
          echo_on = 1;
          drop_on = !insert_stamp(hdr32(12), {hdr32(24), hdr32(20)});
          for (int i = 0; i < 32; i++)
            add(0, hdr[i], i == 31 && pay_left == 0, '0, drop_on);
        end
        if (pay_left == 0) begin
          if (!echo_on) lookup_rtt();
          clear_hunt();
        end else begin
          phase = PAY;
        end
      end else if (phase == PAY) begin
        if (echo_on) add(0, b, pay_left == 1, '0, drop_on);
        pay_left--;
        if (pay_left == 0) begin
          if (!echo_on) lookup_rtt();
          clear_hunt();
        end
      end else begin
        window = {b, window[31:8]};
        if (fill < 4) fill++;
        if (fill == 4 && window == sync_word) begin
          for (int i = 0; i < 4; i++) hdr[i] = window[8*i +: 8];
          hdr_count = 4;
          phase = HEAD;
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
      if (got.echo_byte != want.echo_byte)
        report($sformatf("echo_byte %h want %h", got.echo_byte, want.echo_byte));
      if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
      if (got.rtt_bits != want.rtt_bits)
        report($sformatf("rtt_bits %h want %h", got.rtt_bits, want.rtt_bits));
      if (got.packet_length != want.packet_length)
        report($sformatf("packet_length %h want %h", got.packet_length, want.packet_length));
      if (got.device_id != want.device_id)
        report($sformatf("device_id %h want %h", got.device_id, want.device_id));
      if (got.packet_index != want.packet_index)
        report($sformatf("packet_index %h want %h", got.packet_index, want.packet_index));
      if (got.wifi != want.wifi) report($sformatf("wifi %0d want %0d", got.wifi, want.wifi));
      if (got.dropped != want.dropped)
        report($sformatf("insert_dropped %0d want %0d", got.dropped, want.dropped));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        kind_o, last_o, network_is_wifi_o, insert_dropped_o;
  logic [7:0]  echo_byte_o;
  logic [63:0] rtt_bits_o;
  logic [32:0] packet_length_o;
  logic [31:0] device_id_o, packet_index_o;

  echo_rtt_scoreboard sb = new();
  bit quiet = 0;
  int bytes_sent = 0;
  int packets_sent = 0;

  sync_deframer_echo_rtt_table #(.TABLE_ENTRIES(TB_ENTRIES)) u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= !quiet && $urandom_range(99) < 20;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check({kind_o, echo_byte_o, last_o, rtt_bits_o, packet_length_o, device_id_o,
                packet_index_o, network_is_wifi_o, insert_dropped_o});
  end

  task automatic push_byte(bit [7:0] b);
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_word(bit [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  task automatic send_packet(bit [31:0] dev, bit [31:0] ptype, bit [31:0] key,
                             bit [31:0] net, bit [63:0] stamp, bit [31:0] len);
    push_word(sb.sync_word);
    push_word(dev);
    push_word(ptype);
    push_word(key);
    push_word(net);
    push_word(stamp[31:0]);
    push_word(stamp[63:32]);
    push_word(len);
    for (int i = 0; i < len; i++) push_byte($urandom_range(255));
    packets_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_sync(bit [31:0] w);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.sync_word = w;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic bit [63:0] rand_stamp();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'h7ff0_0000_0000_0000;
      2: return 64'hfff8_0000_0000_0001;
      default: return $realtobits($urandom_range(1000000) / 1024.0);
    endcase
  endfunction

  task automatic random_traffic(int target);
    int stop_at;
    bit [31:0] ptype;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 6)) push_byte($urandom_range(255));
        1: begin
          for (int i = 0; i < $urandom_range(1, 3); i++) push_byte(sb.sync_word[8*i +: 8]);
          push_byte($urandom_range(255));
        end
        default: begin
          ptype = $urandom_range(1) ? 32'd0 : ($urandom_range(3) == 0 ? $urandom : 32'd1);
          send_packet($urandom, ptype, $urandom_range(9) == 0 ? $urandom : $urandom_range(5),
                      $urandom_range(1) ? 32'd0 : $urandom, rand_stamp(),
                      $urandom_range(7) == 0 ? $urandom_range(8, 20) : $urandom_range(3));
        end
      endcase
    end
  endtask

  initial begin
    sb.init();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: insert, hit, stray bytes, repeated index, sync word changes
    send_packet(32'hffff_ffff, 32'd0, 32'd1, 32'd0, $realtobits(1.5), 32'd0);
    send_packet(32'h0, 32'd7, 32'd1, 32'd1, $realtobits(4.25), 32'd0);
    push_byte(8'h00);
    push_byte(8'hff);
    send_packet(32'h0, 32'd0, 32'hffff_ffff, 32'h8000_0000, 64'hffff_ffff_ffff_ffff, 32'd1);
    send_packet(32'h0, 32'd0, 32'hffff_ffff, 32'h0, $realtobits(-2.0), 32'd1);

    write_sync(32'h0000_0000);
    repeat (6) push_byte(8'h00);
    send_packet(32'h5, 32'd3, 32'd77, 32'd0, 64'h0, 32'd0);
    write_sync(32'hffff_ffff);
    send_packet(32'h6, 32'd0, 32'd88, 32'd0, $realtobits(3.0), 32'd0);

    // table full: this insert is dropped, then a lookup with a nan stamp frees an entry
    write_sync(sdert_pkg::SYNC_RESET);
    send_packet(32'h1234_5678, 32'd0, 32'd100, 32'hffff_ffff, $realtobits(7.0), 32'd2);
    send_packet(32'h0, 32'd2, 32'hffff_ffff, 32'h0, 64'hfff8_0000_0000_0001, 32'd3);

    random_traffic(20);
    write_sync($urandom);
    quiet = 1;
    random_traffic(50);
    quiet = 0;
    random_traffic(20);
    drain();

    $display("sent %0d bytes in %0d framed packets", bytes_sent, packets_sent);
    $display("checked %0d echo items, %0d round-trip records, %0d dropped-insert items",
             sb.echoes, sb.records, sb.drops);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end
endmodule
